// ----- rtl/core/gzhp_pkg.sv -----
// ============================================================================
// gzhp_pkg: shared types, constants and functions of the gzip header parser
// Holds the parse phases, status codes, result and configuration structures
// and the byte-wide CRC-32 update used by the parser.
// ============================================================================
package gzhp_pkg;

    localparam logic [7:0]  MAGIC_ID1      = 8'h1F;
    localparam logic [7:0]  MAGIC_ID2      = 8'h8B;
    localparam logic [7:0]  METHOD_DEFLATE = 8'h08;
    localparam logic [7:0]  FLG_RESERVED   = 8'hE0;
    localparam int          FLG_HCRC_BIT    = 1;
    localparam int          FLG_EXTRA_BIT   = 2;
    localparam int          FLG_NAME_BIT    = 3;
    localparam int          FLG_COMMENT_BIT = 4;
    localparam logic [31:0] CRC_POLY       = 32'hEDB88320;
    localparam logic [31:0] FIXED_LEN      = 32'd10;
    localparam logic [31:0] TRAILER_LEN    = 32'd8;
    localparam logic [31:0] MIN_MEMBER_LEN = FIXED_LEN + TRAILER_LEN;
    localparam logic        ITEM_PAYLOAD   = 1'b0;
    localparam logic        ITEM_STATUS    = 1'b1;

    typedef enum logic [1:0] {
        CFG_MEMBER_LENGTH   = 2'd0,
        CFG_SIZE_LIMIT      = 2'd1,
        CFG_BUFFER_CAPACITY = 2'd2
    } cfg_index_t;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_FIXED    = 4'd1,
        PH_XLEN_LO  = 4'd2,
        PH_XLEN_HI  = 4'd3,
        PH_EXTRA    = 4'd4,
        PH_NAME     = 4'd5,
        PH_COMMENT  = 4'd6,
        PH_HCRC_LO  = 4'd7,
        PH_HCRC_HI  = 4'd8,
        PH_PAYLOAD  = 4'd9,
        PH_TRAILER  = 4'd10
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_TRUNCATED  = 3'd1,
        ST_BAD_MAGIC  = 3'd2,
        ST_BAD_METHOD = 3'd3,
        ST_RESERVED   = 3'd4,
        ST_HEADER_CRC = 3'd5,
        ST_LIMIT      = 3'd6,
        ST_TOO_SMALL  = 3'd7
    } status_t;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  payload_byte;
        logic [2:0]  status_code;
        logic [31:0] trailer_crc;
        logic [31:0] trailer_size;
        logic        final_item;
    } result_t;

    typedef struct packed {
        logic [31:0] member_length;
        logic [31:0] trailer_pos;
        logic [31:0] last_pos;
        logic        short_len;
        logic [31:0] size_limit;
        logic [31:0] buffer_capacity;
    } cfg_t;

    // Phase that follows a header section, given the flags and the number of
    // optional sections already behind us (0 fixed, 1 extra, 2 name, 3 comment).
    function automatic phase_t next_phase(input logic [4:0] flags, input logic [1:0] stage);
        phase_t ph;
        if (stage == 2'd0 && flags[FLG_EXTRA_BIT])
            ph = PH_XLEN_LO;
        else if (stage <= 2'd1 && flags[FLG_NAME_BIT])
            ph = PH_NAME;
        else if (stage <= 2'd2 && flags[FLG_COMMENT_BIT])
            ph = PH_COMMENT;
        else if (flags[FLG_HCRC_BIT])
            ph = PH_HCRC_LO;
        else
            ph = PH_PAYLOAD;
        return ph;
    endfunction

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h000000, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/gzip_member_header_parser.sv -----
// ============================================================================
// gzip_member_header_parser: gzip member header parser, top level
// Checks a gzip member byte by byte, passes the deflate payload bytes on and
// closes each member with one status beat, which carries the trailer fields once the trailer is read.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_ready    data_byte, member_start
//   out      source     out_valid/out_ready  item_kind, payload_byte,
//                                            status_code, trailer_crc,
//                                            trailer_size, final_item
//   cfg      sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One byte is taken per cycle while the output buffer has room; each byte passes through the input
// register and its result waits in the two-entry output buffer.
// The per-byte CRC-32 update and length compares are combinational, between the two.
// rst_n clears the registers to length 0 with no member open.
// A stalled output fills the buffer; in_ready then drops until a beat leaves.
// cfg_ready is always high.
// ============================================================================
module gzip_member_header_parser
    import gzhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        member_start,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        item_kind,
    output logic [7:0]  payload_byte,
    output logic [2:0]  status_code,
    output logic [31:0] trailer_crc,
    output logic [31:0] trailer_size,
    output logic        final_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t    cfg;
    logic    res_valid;
    logic    res_ready;
    result_t res;
    result_t out_data;

    gzhp_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gzhp_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .member_start (member_start),
        .cfg          (cfg),
        .res_ready    (res_ready),
        .res_valid    (res_valid),
        .res          (res)
    );

    gzhp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .can_push  (res_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign item_kind    = out_data.item_kind;
    assign payload_byte = out_data.payload_byte;
    assign status_code  = out_data.status_code;
    assign trailer_crc  = out_data.trailer_crc;
    assign trailer_size = out_data.trailer_size;
    assign final_item   = out_data.final_item;

endmodule

// ----- rtl/core/gzhp_cfg_regs.sv -----
// ============================================================================
// gzhp_cfg_regs: configuration registers of the gzip header parser
// Stores the three registers and precomputes the trailer position, the last
// byte position and the short-member flag whenever the length is written.
// ============================================================================
module gzhp_cfg_regs
    import gzhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output cfg_t        cfg
);

    logic [31:0] member_length_reg;
    logic [31:0] trailer_pos_reg;
    logic [31:0] last_pos_reg;
    logic        short_len_reg;
    logic [31:0] size_limit_reg;
    logic [31:0] buffer_capacity_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            member_length_reg   <= '0;
            trailer_pos_reg     <= '0 - TRAILER_LEN;
            last_pos_reg        <= '1;
            short_len_reg       <= 1'b1;
            size_limit_reg      <= '0;
            buffer_capacity_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_MEMBER_LENGTH:
                begin
                    member_length_reg <= cfg_data;
                    trailer_pos_reg   <= cfg_data - TRAILER_LEN;
                    last_pos_reg      <= cfg_data - 32'd1;
                    short_len_reg     <= (cfg_data < MIN_MEMBER_LEN);
                end
                CFG_SIZE_LIMIT:      size_limit_reg      <= cfg_data;
                CFG_BUFFER_CAPACITY: buffer_capacity_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.member_length   = member_length_reg;
    assign cfg.trailer_pos     = trailer_pos_reg;
    assign cfg.last_pos        = last_pos_reg;
    assign cfg.short_len       = short_len_reg;
    assign cfg.size_limit      = size_limit_reg;
    assign cfg.buffer_capacity = buffer_capacity_reg;

    // The derived fields must always agree with the stored length.
    assert property (@(posedge clk) disable iff (!rst_n)
        trailer_pos_reg == member_length_reg - TRAILER_LEN)
        else $error("trailer position out of step with member length");
    assert property (@(posedge clk) disable iff (!rst_n)
        short_len_reg == (member_length_reg < MIN_MEMBER_LEN))
        else $error("short-member flag out of step with member length");
    assert property (@(posedge clk) disable iff (!rst_n)
        last_pos_reg == member_length_reg - 32'd1)
        else $error("last position out of step with member length");

endmodule

// ----- rtl/core/gzhp_parser.sv -----
// ============================================================================
// gzhp_parser: per-byte gzip member header parse step
// An input register feeds one pass of combinational logic that updates the
// parse state and forms at most one result for the output buffer.
// ============================================================================
module gzhp_parser
    import gzhp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       member_start,
    input  cfg_t       cfg,
    input  logic       res_ready,
    output logic       res_valid,
    output result_t    res
);

    // input register
    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       start_reg;
    logic       advance;

    // parse state
    phase_t      phase_reg,   phase_next;
    logic [31:0] pos_reg,     pos_next;
    logic [4:0]  flags_reg,   flags_next;
    logic [15:0] frem_reg,    frem_next;
    logic [31:0] crc_reg,     crc_next;
    logic [7:0]  hcrc_lo_reg, hcrc_lo_next;
    logic [63:0] trailer_reg, trailer_next;
    logic        fin_reg,     fin_next;

    // state as seen by this byte (a start byte sees the fresh member)
    phase_t      phase_eff;
    logic [31:0] pos_eff;
    logic [4:0]  flags_eff;
    logic [15:0] frem_eff;
    logic [31:0] crc_eff;
    logic [7:0]  hcrc_lo_eff;
    logic [63:0] trailer_eff;
    logic        active;

    logic [31:0] crc_upd;
    logic [15:0] frem_dec;
    logic [2:0]  tr_sel;
    logic [63:0] tr_or;
    logic        pos_ge_ml;
    logic        pos_ge_tpos;
    logic        pos_is_last;

    logic        do_finish;
    logic        with_trailer;
    logic        emit_payload;
    status_t     code;

    assign advance  = in_valid_reg && res_ready;
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg  <= data_byte;
            start_reg <= member_start;
        end
    end

    assign active      = start_reg || !fin_reg;
    assign phase_eff   = start_reg ? PH_FIXED : phase_reg;
    assign pos_eff     = start_reg ? '0 : pos_reg;
    assign flags_eff   = start_reg ? '0 : flags_reg;
    assign frem_eff    = start_reg ? '0 : frem_reg;
    assign crc_eff     = start_reg ? '1 : crc_reg;
    assign hcrc_lo_eff = start_reg ? '0 : hcrc_lo_reg;
    assign trailer_eff = start_reg ? '0 : trailer_reg;

    assign crc_upd     = crc_byte(crc_eff, byte_reg);
    assign frem_dec    = frem_eff - 16'd1;
    assign pos_ge_ml   = (pos_eff >= cfg.member_length);
    assign pos_ge_tpos = (pos_eff >= cfg.trailer_pos);
    assign pos_is_last = (pos_eff == cfg.last_pos);
    assign tr_sel      = pos_eff[2:0] - cfg.trailer_pos[2:0];

    always_comb
    begin
        tr_or = trailer_eff;
        tr_or[{tr_sel, 3'b000} +: 8] = trailer_eff[{tr_sel, 3'b000} +: 8] | byte_reg;
    end

    // Next-state logic: one parse step per beat that leaves the input register while a member is open.
    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        flags_next   = flags_reg;
        frem_next    = frem_reg;
        crc_next     = crc_reg;
        hcrc_lo_next = hcrc_lo_reg;
        trailer_next = trailer_reg;
        fin_next     = fin_reg;
        do_finish    = 1'b0;
        with_trailer = 1'b0;
        emit_payload = 1'b0;
        code         = ST_OK;

        if (advance && active)
        begin
            phase_next   = phase_eff;
            pos_next     = pos_eff + 32'd1;
            flags_next   = flags_eff;
            frem_next    = frem_eff;
            crc_next     = crc_eff;
            hcrc_lo_next = hcrc_lo_eff;
            trailer_next = trailer_eff;
            fin_next     = 1'b0;

            if (cfg.short_len || pos_ge_ml)
            begin
                do_finish = 1'b1;
                code      = ST_TRUNCATED;
            end
            else if ((phase_eff inside {[PH_XLEN_LO:PH_HCRC_HI]}) && pos_ge_tpos)
            begin
                // optional header fields must end before the trailer
                do_finish = 1'b1;
                code      = ST_TRUNCATED;
            end
            else
            begin
                case (phase_eff)
                    PH_FIXED:
                    begin
                        crc_next = crc_upd;
                        if (pos_eff == 32'd0 && byte_reg != MAGIC_ID1)
                        begin
                            do_finish = 1'b1;
                            code      = ST_BAD_MAGIC;
                        end
                        else if (pos_eff == 32'd1 && byte_reg != MAGIC_ID2)
                        begin
                            do_finish = 1'b1;
                            code      = ST_BAD_MAGIC;
                        end
                        else if (pos_eff == 32'd2 && byte_reg != METHOD_DEFLATE)
                        begin
                            do_finish = 1'b1;
                            code      = ST_BAD_METHOD;
                        end
                        else if (pos_eff == 32'd3 && (byte_reg & FLG_RESERVED) != 8'h00)
                        begin
                            do_finish = 1'b1;
                            code      = ST_RESERVED;
                        end
                        else
                        begin
                            if (pos_eff == 32'd3)
                                flags_next = byte_reg[4:0];
                            if (pos_eff >= FIXED_LEN - 32'd1)
                                phase_next = next_phase(flags_eff, 2'd0);
                        end
                    end
                    PH_XLEN_LO:
                    begin
                        crc_next   = crc_upd;
                        frem_next  = {8'h00, byte_reg};
                        phase_next = PH_XLEN_HI;
                    end
                    PH_XLEN_HI:
                    begin
                        crc_next   = crc_upd;
                        frem_next  = {byte_reg, frem_eff[7:0]};
                        phase_next = ({byte_reg, frem_eff[7:0]} == 16'h0000)
                                     ? next_phase(flags_eff, 2'd1) : PH_EXTRA;
                    end
                    PH_EXTRA:
                    begin
                        crc_next  = crc_upd;
                        frem_next = frem_dec;
                        if (frem_dec == 16'h0000)
                            phase_next = next_phase(flags_eff, 2'd1);
                    end
                    PH_NAME:
                    begin
                        crc_next = crc_upd;
                        if (byte_reg == 8'h00)
                            phase_next = next_phase(flags_eff, 2'd2);
                    end
                    PH_COMMENT:
                    begin
                        crc_next = crc_upd;
                        if (byte_reg == 8'h00)
                            phase_next = next_phase(flags_eff, 2'd3);
                    end
                    PH_HCRC_LO:
                    begin
                        hcrc_lo_next = byte_reg;
                        phase_next   = PH_HCRC_HI;
                    end
                    PH_HCRC_HI:
                    begin
                        if ({byte_reg, hcrc_lo_eff} != ~crc_eff[15:0])
                        begin
                            do_finish = 1'b1;
                            code      = ST_HEADER_CRC;
                        end
                        else
                            phase_next = PH_PAYLOAD;
                    end
                    default:
                    begin
                        if (!pos_ge_tpos)
                            emit_payload = 1'b1;
                        else
                        begin
                            phase_next   = PH_TRAILER;
                            trailer_next = tr_or;
                            if (pos_is_last)
                            begin
                                do_finish    = 1'b1;
                                with_trailer = 1'b1;
                                if (tr_or[63:32] > cfg.size_limit)
                                    code = ST_LIMIT;
                                else if (tr_or[63:32] > cfg.buffer_capacity)
                                    code = ST_TOO_SMALL;
                                else
                                    code = ST_OK;
                            end
                        end
                    end
                endcase
            end

            if (do_finish)
            begin
                fin_next   = 1'b1;
                phase_next = PH_IDLE;
            end
        end
    end

    // Output logic: a payload byte or the closing status beat.
    always_comb
    begin
        res_valid        = advance && active && (do_finish || emit_payload);
        res.item_kind    = do_finish ? ITEM_STATUS : ITEM_PAYLOAD;
        res.payload_byte = do_finish ? 8'h00 : byte_reg;
        res.status_code  = do_finish ? code : ST_OK;
        res.trailer_crc  = with_trailer ? tr_or[31:0] : 32'h0;
        res.trailer_size = with_trailer ? tr_or[63:32] : 32'h0;
        res.final_item   = do_finish;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            pos_reg     <= '0;
            flags_reg   <= '0;
            frem_reg    <= '0;
            crc_reg     <= '1;
            hcrc_lo_reg <= '0;
            trailer_reg <= '0;
            fin_reg     <= 1'b1;
        end
        else
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            flags_reg   <= flags_next;
            frem_reg    <= frem_next;
            crc_reg     <= crc_next;
            hcrc_lo_reg <= hcrc_lo_next;
            trailer_reg <= trailer_next;
            fin_reg     <= fin_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg == (phase_reg == PH_IDLE))
        else $error("finished flag and idle phase disagree");
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.final_item |=> fin_reg)
        else $error("status beat did not close the member");
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.final_item |=> pos_reg == $past(pos_eff) + 32'd1)
        else $error("payload beat did not advance the byte position");
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_ready)
        else $error("result formed while the output buffer is full");

endmodule

// ----- rtl/core/gzhp_out_buf.sv -----
// ============================================================================
// gzhp_out_buf: two-entry result buffer
// Registers each result and decouples output stalls from the parse step, so
// a new byte is taken while a finished result still waits.
// ============================================================================
module gzhp_out_buf
    import gzhp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    can_push,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    result_t    entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;
    logic       pop;

    assign can_push  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result buffer count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 2'd1)
        else $error("result buffer lost a beat");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("result buffer pointers out of step");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ============================================================================
// testbench: self-checking bench for the gzip member header parser
// Streams well-formed gzip members with random headers, payload and trailers,
// mixed with damaged members, restarts and stray bytes. Each accepted byte
// goes through an in-bench parser model, and every output beat is compared
// against the oldest predicted beat.
// ============================================================================
module testbench;
    import gzhp_pkg::*;

    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          RANDOM_ITEMS  = 1400;
    localparam int          MAX_REPORTS   = 10;
    localparam int          SETTLE_CYCLES = 8;
    localparam logic [31:0] ALL_ONES      = 32'hFFFF_FFFF;

    typedef enum int {
        FLAW_NONE,
        FLAW_MAGIC,
        FLAW_METHOD,
        FLAW_RESERVED,
        FLAW_HCRC,
        FLAW_CUT,
        FLAW_TAIL,
        FLAW_HDR_OVERRUN
    } flaw_t;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } in_beat_t;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte    = 8'h00;
    logic        member_start = 1'b0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [2:0]  status_code;
    logic [31:0] trailer_crc;
    logic [31:0] trailer_size;
    logic        final_item;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index    = 2'd0;
    logic [31:0] cfg_data     = 32'd0;

    gzip_member_header_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .member_start (member_start),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .item_kind    (item_kind),
        .payload_byte (payload_byte),
        .status_code  (status_code),
        .trailer_crc  (trailer_crc),
        .trailer_size (trailer_size),
        .final_item   (final_item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Stimulus bookkeeping.
    in_beat_t    pending_bytes[$];
    logic [7:0]  member_bytes[$];
    int          beats_queued   = 0;
    int          beats_taken    = 0;
    int          items_sent     = 0;
    int          error_count    = 0;
    int          cycle_count    = 0;
    int          gap_left       = 0;
    int          stall_left     = 0;
    bit          quiet_phase    = 1'b0;
    logic        in_taken       = 1'b0;
    logic        cfg_taken      = 1'b0;
    logic [31:0] cur_limit      = 32'd0;
    logic [31:0] cur_capacity   = 32'd0;
    in_beat_t    next_beat;
    result_t     want_beat;

    // Parser model state and its copy of the registers.
    result_t     expected_beats[$];
    logic [31:0] cfg_member_length;
    logic [31:0] cfg_size_limit;
    logic [31:0] cfg_capacity;
    phase_t      mdl_phase;
    logic [31:0] mdl_pos;
    logic [4:0]  mdl_flags;
    logic [15:0] mdl_remaining;
    logic [31:0] mdl_crc;
    logic [15:0] mdl_hdr_check;
    logic [63:0] mdl_trailer;
    logic        mdl_closed;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Reflected CRC-32, one data bit at a time.
    function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    // Section that follows once `done` optional sections are behind us.
    function automatic phase_t section_after(input logic [4:0] flags, input int done);
        if (done == 0 && flags[FLG_EXTRA_BIT])
            return PH_XLEN_LO;
        if (done <= 1 && flags[FLG_NAME_BIT])
            return PH_NAME;
        if (done <= 2 && flags[FLG_COMMENT_BIT])
            return PH_COMMENT;
        if (flags[FLG_HCRC_BIT])
            return PH_HCRC_LO;
        return PH_PAYLOAD;
    endfunction

    function automatic void close_member(input status_t code, input bit with_trailer);
        result_t r;
        r.item_kind    = ITEM_STATUS;
        r.payload_byte = 8'h00;
        r.status_code  = code;
        r.trailer_crc  = with_trailer ? mdl_trailer[31:0] : 32'd0;
        r.trailer_size = with_trailer ? mdl_trailer[63:32] : 32'd0;
        r.final_item   = 1'b1;
        expected_beats.push_back(r);
        mdl_closed = 1'b1;
        mdl_phase  = PH_IDLE;
    endfunction

    function automatic void predict_parser_output(input logic [7:0] b, input logic start);
        logic [31:0] pos;
        logic [31:0] tpos;
        result_t     r;
        if (start)
        begin
            mdl_phase     = PH_FIXED;
            mdl_pos       = 32'd0;
            mdl_flags     = 5'd0;
            mdl_remaining = 16'd0;
            mdl_crc       = ALL_ONES;
            mdl_hdr_check = 16'd0;
            mdl_trailer   = 64'd0;
            mdl_closed    = 1'b0;
        end
        else if (mdl_closed)
            return;

        pos = mdl_pos;
        if (cfg_member_length < MIN_MEMBER_LEN || pos >= cfg_member_length)
        begin
            close_member(ST_TRUNCATED, 1'b0);
            return;
        end
        tpos = cfg_member_length - TRAILER_LEN;

        // Optional header fields may not run into the trailer.
        if (mdl_phase >= PH_XLEN_LO && mdl_phase <= PH_HCRC_HI && pos >= tpos)
        begin
            close_member(ST_TRUNCATED, 1'b0);
            return;
        end

        case (mdl_phase)
            PH_FIXED:
            begin
                mdl_crc = crc32_update(mdl_crc, b);
                if ((pos == 0 && b != MAGIC_ID1) || (pos == 1 && b != MAGIC_ID2))
                begin
                    close_member(ST_BAD_MAGIC, 1'b0);
                    return;
                end
                if (pos == 2 && b != METHOD_DEFLATE)
                begin
                    close_member(ST_BAD_METHOD, 1'b0);
                    return;
                end
                if (pos == 3)
                begin
                    if ((b & FLG_RESERVED) != 8'h00)
                    begin
                        close_member(ST_RESERVED, 1'b0);
                        return;
                    end
                    mdl_flags = b[4:0];
                end
                if (pos >= FIXED_LEN - 1)
                    mdl_phase = section_after(mdl_flags, 0);
            end
            PH_XLEN_LO:
            begin
                mdl_crc       = crc32_update(mdl_crc, b);
                mdl_remaining = {8'h00, b};
                mdl_phase     = PH_XLEN_HI;
            end
            PH_XLEN_HI:
            begin
                mdl_crc             = crc32_update(mdl_crc, b);
                mdl_remaining[15:8] = b;
                mdl_phase = (mdl_remaining == 16'd0) ? section_after(mdl_flags, 1) : PH_EXTRA;
            end
            PH_EXTRA:
            begin
                mdl_crc       = crc32_update(mdl_crc, b);
                mdl_remaining = mdl_remaining - 16'd1;
                if (mdl_remaining == 16'd0)
                    mdl_phase = section_after(mdl_flags, 1);
            end
            PH_NAME:
            begin
                mdl_crc = crc32_update(mdl_crc, b);
                if (b == 8'h00)
                    mdl_phase = section_after(mdl_flags, 2);
            end
            PH_COMMENT:
            begin
                mdl_crc = crc32_update(mdl_crc, b);
                if (b == 8'h00)
                    mdl_phase = section_after(mdl_flags, 3);
            end
            PH_HCRC_LO:
            begin
                mdl_hdr_check = {8'h00, b};
                mdl_phase     = PH_HCRC_HI;
            end
            PH_HCRC_HI:
            begin
                mdl_hdr_check[15:8] = b;
                if (mdl_hdr_check != ~mdl_crc[15:0])
                begin
                    close_member(ST_HEADER_CRC, 1'b0);
                    return;
                end
                mdl_phase = PH_PAYLOAD;
            end
            default:
            begin
                if (pos < tpos)
                begin
                    mdl_pos        = pos + 32'd1;
                    r.item_kind    = ITEM_PAYLOAD;
                    r.payload_byte = b;
                    r.status_code  = ST_OK;
                    r.trailer_crc  = 32'd0;
                    r.trailer_size = 32'd0;
                    r.final_item   = 1'b0;
                    expected_beats.push_back(r);
                    return;
                end
                mdl_phase   = PH_TRAILER;
                mdl_trailer = mdl_trailer | ({56'd0, b} << (8 * ((pos - tpos) & 32'd7)));
                if (pos == cfg_member_length - 32'd1)
                begin
                    // The size limit wins over the buffer capacity.
                    if (mdl_trailer[63:32] > cfg_size_limit)
                        close_member(ST_LIMIT, 1'b1);
                    else if (mdl_trailer[63:32] > cfg_capacity)
                        close_member(ST_TOO_SMALL, 1'b1);
                    else
                        close_member(ST_OK, 1'b1);
                    return;
                end
            end
        endcase
        mdl_pos = pos + 32'd1;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet_phase)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_bound();
        case ($urandom_range(0, 4))
            0:       return 32'd0;
            1:       return ALL_ONES;
            2:       return $urandom;
            default: return $urandom_range(0, 400);
        endcase
    endfunction

    // Trailer sizes cluster around the configured bounds.
    function automatic logic [31:0] pick_size();
        case ($urandom_range(0, 6))
            0:       return cur_limit;
            1:       return cur_limit + 32'd1;
            2:       return cur_capacity;
            3:       return cur_capacity + 32'd1;
            4:       return 32'd0;
            5:       return ALL_ONES;
            default: return $urandom;
        endcase
    endfunction

    function automatic flaw_t pick_flaw();
        case ($urandom_range(0, 19))
            0:       return FLAW_MAGIC;
            1:       return FLAW_METHOD;
            2:       return FLAW_RESERVED;
            3, 4:    return FLAW_HCRC;
            5, 6:    return FLAW_CUT;
            7:       return FLAW_TAIL;
            8:       return FLAW_HDR_OVERRUN;
            default: return FLAW_NONE;
        endcase
    endfunction

    function automatic void push_beat(input logic [7:0] b, input logic start, input bit counted);
        in_beat_t beat;
        beat.data  = b;
        beat.start = start;
        pending_bytes.push_back(beat);
        beats_queued++;
        if (counted)
            items_sent++;
    endfunction

    // Fills member_bytes with one member built for the given total length.
    function automatic void build_member(input logic [31:0] total, input flaw_t flaw);
        logic [7:0]  flg;
        logic [31:0] crc;
        logic [31:0] word;
        logic [15:0] hcheck;
        int          fit;
        int          cap;
        int          xlen;
        int          pay_n;
        int          attempt;
        int          idx;
        fit     = (total > 32'd1000) ? 990 : int'(total) - 8;
        cap     = (total > 32'd80) ? 80 : int'(total);
        attempt = 0;

        if (flaw == FLAW_HDR_OVERRUN)
        begin
            // Either a huge extra field or a name without its terminator.
            member_bytes.delete();
            flg = {3'b000, 5'($urandom)};
            if ($urandom_range(0, 1) == 0)
                flg[FLG_EXTRA_BIT] = 1'b1;
            else
            begin
                flg[FLG_EXTRA_BIT] = 1'b0;
                flg[FLG_NAME_BIT]  = 1'b1;
            end
            member_bytes.push_back(MAGIC_ID1);
            member_bytes.push_back(MAGIC_ID2);
            member_bytes.push_back(METHOD_DEFLATE);
            member_bytes.push_back(flg);
            repeat (6) member_bytes.push_back(8'($urandom));
            if (flg[FLG_EXTRA_BIT])
            begin
                xlen = $urandom_range(200, 65535);
                member_bytes.push_back(8'(xlen));
                member_bytes.push_back(8'(xlen >> 8));
            end
            while (member_bytes.size() < cap)
                member_bytes.push_back(8'($urandom_range(1, 255)));
            return;
        end

        do
        begin
            member_bytes.delete();
            flg = {3'b000, 5'($urandom)};
            if (attempt >= 3)
                flg[4:1] = 4'b0000;
            if (flaw == FLAW_HCRC)
                flg[FLG_HCRC_BIT] = 1'b1;
            attempt++;
            member_bytes.push_back(MAGIC_ID1);
            member_bytes.push_back(MAGIC_ID2);
            member_bytes.push_back(METHOD_DEFLATE);
            member_bytes.push_back(flg);
            repeat (6) member_bytes.push_back(8'($urandom));
            if (flg[FLG_EXTRA_BIT])
            begin
                xlen = $urandom_range(0, 6);
                member_bytes.push_back(8'(xlen));
                member_bytes.push_back(8'(xlen >> 8));
                repeat (xlen) member_bytes.push_back(8'($urandom));
            end
            if (flg[FLG_NAME_BIT])
            begin
                repeat ($urandom_range(0, 5)) member_bytes.push_back(8'($urandom_range(1, 255)));
                member_bytes.push_back(8'h00);
            end
            if (flg[FLG_COMMENT_BIT])
            begin
                repeat ($urandom_range(0, 5)) member_bytes.push_back(8'($urandom_range(1, 255)));
                member_bytes.push_back(8'h00);
            end
            if (flg[FLG_HCRC_BIT])
            begin
                crc = ALL_ONES;
                foreach (member_bytes[i])
                    crc = crc32_update(crc, member_bytes[i]);
                hcheck = ~crc[15:0];
                if (flaw == FLAW_HCRC)
                    hcheck = hcheck ^ (16'(1) << $urandom_range(0, 15));
                member_bytes.push_back(hcheck[7:0]);
                member_bytes.push_back(hcheck[15:8]);
            end
        end
        while (member_bytes.size() > fit && attempt < 5);

        case (flaw)
            FLAW_MAGIC:
            begin
                idx = $urandom_range(0, 1);
                member_bytes[idx] = member_bytes[idx] ^ 8'($urandom_range(1, 255));
            end
            FLAW_METHOD:
            begin
                member_bytes[2] = METHOD_DEFLATE ^ 8'($urandom_range(1, 255));
            end
            FLAW_RESERVED:
            begin
                member_bytes[3] = member_bytes[3] | {3'($urandom_range(1, 7)), 5'b00000};
            end
            default:
            begin
            end
        endcase

        // A length too large to stream gets a short payload and no trailer.
        pay_n = (total > 32'd1000) ? 20 : int'(total) - 8 - member_bytes.size();
        for (int k = 0; k < pay_n; k++)
            member_bytes.push_back(8'($urandom));
        if (total <= 32'd1000)
        begin
            word = $urandom;
            for (int k = 0; k < 4; k++)
                member_bytes.push_back(8'(word >> (8 * k)));
            word = pick_size();
            for (int k = 0; k < 4; k++)
                member_bytes.push_back(8'(word >> (8 * k)));
        end

        if (flaw == FLAW_CUT)
        begin
            idx = $urandom_range(1, member_bytes.size() - 1);
            while (member_bytes.size() > idx)
                void'(member_bytes.pop_back());
        end
        else if (flaw == FLAW_TAIL)
            repeat ($urandom_range(1, 3)) member_bytes.push_back(8'($urandom));
    endfunction

    task automatic wait_results();
        do
            @(negedge clk);
        while (beats_taken != beats_queued || expected_beats.size() != 0);
    endtask

    // Bytes without a result may still sit inside the block.
    task automatic wait_drain();
        wait_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [31:0] len, input logic [31:0] limit,
                             input logic [31:0] capacity);
        cur_limit    = limit;
        cur_capacity = capacity;
        write_reg(CFG_MEMBER_LENGTH, len);
        write_reg(CFG_SIZE_LIMIT, limit);
        write_reg(CFG_BUFFER_CAPACITY, capacity);
    endtask

    // Optionally holds the sender mid-member until all results are out.
    task automatic send_member(input bit pause);
        int split;
        split = pause ? $urandom_range(1, member_bytes.size() - 1) : member_bytes.size();
        for (int k = 0; k < member_bytes.size(); k++)
        begin
            if (k == split)
                wait_results();
            push_beat(member_bytes[k], k == 0, 1'b1);
        end
    endtask

    // Input driver.
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (gap_left > 0 || pending_bytes.size() == 0)
            begin
                in_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end
            else
            begin
                next_beat     = pending_bytes.pop_front();
                in_valid     <= 1'b1;
                data_byte    <= next_beat.data;
                member_start <= next_beat.start;
                gap_left      = pick_gap();
            end
        end
    end

    // Output back-pressure.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // Monitor: register writes, accepted bytes and output beats.
    always @(posedge clk)
    begin
        in_taken  <= rst_n && in_valid && in_ready;
        cfg_taken <= rst_n && cfg_valid && cfg_ready;
        if (!rst_n)
        begin
            cfg_member_length = 32'd0;
            cfg_size_limit    = 32'd0;
            cfg_capacity      = 32'd0;
            mdl_phase         = PH_IDLE;
            mdl_pos           = 32'd0;
            mdl_flags         = 5'd0;
            mdl_remaining     = 16'd0;
            mdl_crc           = ALL_ONES;
            mdl_hdr_check     = 16'd0;
            mdl_trailer       = 64'd0;
            mdl_closed        = 1'b1;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MEMBER_LENGTH:   cfg_member_length = cfg_data;
                    CFG_SIZE_LIMIT:      cfg_size_limit    = cfg_data;
                    CFG_BUFFER_CAPACITY: cfg_capacity      = cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            // Compare first: a beat seen now never stems from the byte taken now.
            if (out_valid && out_ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("ERROR: unexpected beat kind=%0d byte=%02h status=%0d",
                                 item_kind, payload_byte, status_code,
                                 " crc=%08h size=%08h last=%0d",
                                 trailer_crc, trailer_size, final_item);
                end
                else
                begin
                    want_beat = expected_beats.pop_front();
                    if (item_kind !== want_beat.item_kind ||
                        payload_byte !== want_beat.payload_byte ||
                        status_code !== want_beat.status_code ||
                        trailer_crc !== want_beat.trailer_crc ||
                        trailer_size !== want_beat.trailer_size ||
                        final_item !== want_beat.final_item)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("ERROR: beat mismatch at %0t:", $realtime,
                                     " expected kind=%0d byte=%02h status=%0d",
                                     want_beat.item_kind, want_beat.payload_byte,
                                     want_beat.status_code,
                                     " crc=%08h size=%08h last=%0d,",
                                     want_beat.trailer_crc, want_beat.trailer_size,
                                     want_beat.final_item,
                                     " got kind=%0d byte=%02h status=%0d",
                                     item_kind, payload_byte, status_code,
                                     " crc=%08h size=%08h last=%0d",
                                     trailer_crc, trailer_size, final_item);
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                beats_taken++;
                predict_parser_output(data_byte, member_start);
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("ERROR: no progress within %0d cycles", CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        logic [31:0] len;
        int          open_n;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // A stray byte with no member open, then a member against length zero.
        push_beat(8'($urandom), 1'b0, 1'b0);
        push_beat(MAGIC_ID1, 1'b1, 1'b1);
        wait_drain();

        // Smallest legal member, reaching both bounds at their maximum.
        configure(MIN_MEMBER_LEN, ALL_ONES, ALL_ONES);
        push_beat(MAGIC_ID1, 1'b1, 1'b1);
        push_beat(MAGIC_ID2, 1'b0, 1'b1);
        push_beat(METHOD_DEFLATE, 1'b0, 1'b1);
        push_beat(8'h00, 1'b0, 1'b1);
        repeat (6) push_beat(8'h00, 1'b0, 1'b1);
        repeat (4) push_beat(8'hFF, 1'b0, 1'b1);
        repeat (4) push_beat(8'hFF, 1'b0, 1'b1);
        // Each broken fixed-header field in turn.
        push_beat(8'h1E, 1'b1, 1'b1);
        push_beat(MAGIC_ID1, 1'b1, 1'b1);
        push_beat(8'h8A, 1'b0, 1'b1);
        push_beat(MAGIC_ID1, 1'b1, 1'b1);
        push_beat(MAGIC_ID2, 1'b0, 1'b1);
        push_beat(8'h07, 1'b0, 1'b1);
        push_beat(MAGIC_ID1, 1'b1, 1'b1);
        push_beat(MAGIC_ID2, 1'b0, 1'b1);
        push_beat(METHOD_DEFLATE, 1'b0, 1'b1);
        push_beat(FLG_RESERVED, 1'b0, 1'b1);
        wait_drain();

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 19))
                0, 1:    len = $urandom_range(0, 17);
                2:       len = ALL_ONES;
                3, 4:    len = MIN_MEMBER_LEN;
                5:       len = $urandom_range(71, 160);
                default: len = $urandom_range(19, 70);
            endcase
            quiet_phase = ($urandom_range(0, 4) == 0);
            configure(len, pick_bound(), pick_bound());

            if (len < MIN_MEMBER_LEN)
            begin
                // A later byte may still find a member left open earlier.
                repeat ($urandom_range(2, 4))
                begin
                    push_beat(8'($urandom), 1'b0, 1'b1);
                    push_beat(8'($urandom), 1'b1, 1'b1);
                end
            end
            else
            begin
                repeat ($urandom_range(3, 8))
                begin
                    build_member(len, pick_flaw());
                    send_member($urandom_range(0, 9) == 0);
                end
                if ($urandom_range(0, 5) == 0)
                begin
                    // Leave a member open, then pull the length to or below its position.
                    build_member(len, FLAW_NONE);
                    open_n = $urandom_range(1, member_bytes.size() - 1);
                    for (int k = 0; k < open_n; k++)
                        push_beat(member_bytes[k], k == 0, 1'b1);
                    wait_drain();
                    write_reg(CFG_MEMBER_LENGTH, $urandom_range(0, open_n));
                    push_beat(8'($urandom), 1'b0, 1'b1);
                    push_beat(8'($urandom), 1'b0, 1'b1);
                end
            end
            wait_drain();
        end

        quiet_phase = 1'b0;
        wait_drain();
        if (error_count == 0 && expected_beats.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/gzhp_pkg.sv
rtl/core/gzhp_cfg_regs.sv
rtl/core/gzhp_parser.sv
rtl/core/gzhp_out_buf.sv
rtl/core/gzip_member_header_parser.sv
bench/testbench.sv
